FILE: hw/rtl/sysex_name_setting_parser_defines.svh
// assertion helpers for the name-setting parser
`ifndef SYSEX_NAME_SETTING_PARSER_DEFINES_SVH
`define SYSEX_NAME_SETTING_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define NSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsp check failed");
`define NSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsp check failed");
`else
`define NSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/sysex_nsp_pkg.sv
`timescale 1ns / 1ps
package sysex_nsp_pkg;

    localparam int NAME_MAX_DEF = 16;
    localparam int HDR_LEN      = 4;
    localparam int ID_LEN       = 4;

    localparam logic [7:0]  END_BYTE  = 8'hF7;
    localparam logic [31:0] SIG_RESET = 32'hF07D1A55;

    localparam logic OP_ERASE   = 1'b0;
    localparam logic OP_PROGRAM = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_EMIT,
        ST_FETCH
    } nsp_state_t;

endpackage

FILE: hw/rtl/sysex_nsp_if.sv
`timescale 1ns / 1ps
// byte stream in
interface sysex_nsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// storage command stream out
interface sysex_nsp_cmd_if;
    logic        valid;
    logic        ready;
    logic        store_op;
    logic [4:0]  word_index;
    logic [15:0] word_data;
    logic        last_of_run;

    modport source (output valid, output store_op, output word_index,
                    output word_data, output last_of_run, input ready);
    modport sink (input valid, input store_op, input word_index,
                  input word_data, input last_of_run, output ready);
endinterface

// header signature write
interface sysex_nsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_signature;

    modport source (output valid, output header_signature, input ready);
    modport sink (input valid, input header_signature, output ready);
endinterface

FILE: hw/rtl/sysex_nsp_name_ram.sv
`timescale 1ns / 1ps
module sysex_nsp_name_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sysex_name_setting_parser.sv
`timescale 1ns / 1ps
// channel    | modport | payload                                   | handshake
// in_chan    | sink    | data_byte[7:0]                            | valid/ready
// out_chan   | source  | store_op, word_index[4:0], word_data[15:0], | valid/ready
//            |         | last_of_run                               |
// cfg_chan   | sink    | header_signature[31:0]                    | valid/ready
//
// a byte is accepted, then makes one pass through the byte comparator,
// which is shared by header matching and end-byte detection
// the end byte then drives a run of 1 to NAME_MAX+4 commands, paced by the
// registered read of the name memory
// rst_n clears the parser to idle with the reset signature; the name memory
// is not cleared, only entries written by the current message are read
// a stalled out_chan holds the run; input bytes are taken only while idle
`include "sysex_name_setting_parser_defines.svh"
module sysex_name_setting_parser
#(
    parameter int NAME_MAX = sysex_nsp_pkg::NAME_MAX_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    sysex_nsp_byte_if.sink          in_chan,
    sysex_nsp_cmd_if.source         out_chan,
    sysex_nsp_cfg_if.sink           cfg_chan
);

    import sysex_nsp_pkg::*;

    // position covers header, id and name phases
    localparam int POS_MAX = HDR_LEN + ID_LEN + NAME_MAX;
    localparam int PW      = $clog2(POS_MAX + 1);
    // run counter reaches name length plus three (terminator)
    localparam int CW      = $clog2(NAME_MAX + 4);
    localparam int LW      = $clog2(NAME_MAX + 1);
    localparam int AW      = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    nsp_state_t      state_reg, state_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     pid_reg, pid_next;
    logic [LW-1:0]   name_len_reg, name_len_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      byte_reg, byte_next;
    logic [31:0]     sig_reg;

    logic            out_valid_reg, out_valid_next;
    logic            op_reg, op_next;
    logic [4:0]      idx_reg, idx_next;
    logic [15:0]     data_reg, data_next;
    logic            last_reg, last_next;

    // shared byte comparator
    logic [7:0]      cmp_ref;
    logic            cmp_hit;

    logic [PW-1:0]   slot;
    logic            ram_we;
    logic [AW-1:0]   ram_rd_addr;
    logic [7:0]      ram_rd_data;
    logic [CW-1:0]   name_pos;
    logic [CW-1:0]   idx_wide;
    logic            out_free;
    logic            load;

    sysex_nsp_name_ram #(
        .DEPTH (NAME_MAX),
        .AW    (AW)
    ) u_name_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (slot[AW-1:0]),
        .wr_data (byte_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // header byte for the current position, else the end byte
    always_comb
    begin
        cmp_ref = END_BYTE;
        if (pos_reg < PW'(HDR_LEN))
        begin
            unique case (pos_reg[1:0])
                2'd0:    cmp_ref = sig_reg[31:24];
                2'd1:    cmp_ref = sig_reg[23:16];
                2'd2:    cmp_ref = sig_reg[15:8];
                default: cmp_ref = sig_reg[7:0];
            endcase
        end
    end

    assign cmp_hit     = (byte_reg == cmp_ref);
    assign slot        = pos_reg - PW'(HDR_LEN + ID_LEN);
    assign name_pos    = cnt_reg - CW'(3);
    assign idx_wide    = cnt_reg - CW'(1);
    assign ram_rd_addr = name_pos[AW-1:0];
    assign out_free    = !out_valid_reg || out_chan.ready;

    assign in_chan.ready       = (state_reg == ST_IDLE);
    assign cfg_chan.ready      = 1'b1;
    assign out_chan.valid      = out_valid_reg;
    assign out_chan.store_op   = op_reg;
    assign out_chan.word_index = idx_reg;
    assign out_chan.word_data  = data_reg;
    assign out_chan.last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            pid_reg       <= '0;
            name_len_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            sig_reg       <= SIG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pid_reg       <= pid_next;
            name_len_reg  <= name_len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_chan.valid)
            begin
                sig_reg <= cfg_chan.header_signature;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pid_next       = pid_reg;
        name_len_next  = name_len_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        load           = 1'b0;

        // word taken downstream
        if (out_valid_reg && out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_chan.valid)
                begin
                    byte_next  = in_chan.data_byte;
                    state_next = ST_PARSE;
                end
            end

            ST_PARSE:
            begin
                state_next = ST_IDLE;
                priority if (pos_reg < PW'(HDR_LEN))
                begin
                    if (cmp_hit)
                    begin
                        pos_next = PW'(pos_reg + 1'b1);
                        // fresh message: forget the previous name length
                        if (pos_reg == PW'(HDR_LEN - 1))
                        begin
                            name_len_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = '0;
                    end
                end
                else if (cmp_hit)
                begin
                    // end byte: start the command run
                    pos_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (pos_reg < PW'(HDR_LEN + ID_LEN))
                begin
                    // id nibbles, least significant first
                    unique case (pos_reg[1:0])
                        2'd0:    pid_next = {12'h000, byte_reg[3:0]};
                        2'd1:    pid_next[7:4] = byte_reg[3:0];
                        2'd2:    pid_next[11:8] = byte_reg[3:0];
                        default: pid_next[15:12] = byte_reg[3:0];
                    endcase
                    pos_next = PW'(pos_reg + 1'b1);
                end
                else if (slot < PW'(NAME_MAX))
                begin
                    ram_we   = 1'b1;
                    pos_next = PW'(pos_reg + 1'b1);
                    // name length stops growing at the first zero byte
                    if (name_len_reg == slot[LW-1:0] && byte_reg != 8'h00)
                    begin
                        name_len_next = LW'(name_len_reg + 1'b1);
                    end
                end
                else
                begin
                    // name overflow, byte dropped
                    pos_next = pos_reg;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    op_next        = OP_PROGRAM;
                    idx_next       = 5'(idx_wide);
                    data_next      = 16'h0000;
                    last_next      = 1'b0;
                    priority if (cnt_reg == CW'(0))
                    begin
                        op_next   = OP_ERASE;
                        idx_next  = 5'd0;
                        last_next = (name_len_reg == '0);
                    end
                    else if (cnt_reg == CW'(1))
                    begin
                        idx_next = 5'd0;
                    end
                    else if (cnt_reg == CW'(2))
                    begin
                        data_next = pid_reg;
                    end
                    else if (name_pos < CW'(name_len_reg))
                    begin
                        data_next = {8'h00, ram_rd_data};
                    end
                    else
                    begin
                        // zero terminator closes the run
                        last_next = 1'b1;
                    end

                    if (last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = CW'(cnt_reg + 1'b1);
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                // lets the registered name read land
                state_next = ST_EMIT;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `NSP_ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_reg <= PW'(POS_MAX))
    `NSP_ASSERT_IMPL(a_len_range, clk, rst_n, 1'b1, name_len_reg <= LW'(NAME_MAX))
    `NSP_ASSERT_NEXT(a_fetch_emit, clk, rst_n, state_reg == ST_FETCH, state_reg == ST_EMIT)
    `NSP_ASSERT_NEXT(a_run_end, clk, rst_n, load && last_next, state_reg == ST_IDLE && out_valid_reg)
    `NSP_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_reg == ST_EMIT, cnt_reg <= CW'(name_len_reg) + CW'(3))

endmodule

FILE: tb/sysex_name_setting_parser_tb.sv
`timescale 1ns / 1ps
// byte-level checks of the sysex name-setting parser
module sysex_name_setting_parser_tb;
    import sysex_nsp_pkg::*;

    // how long to let the parser settle once nothing is owed any more
    localparam int SETTLE_CYCLES    = 10;
    localparam int END_CYCLES       = 40;
    // receiver hold-off in the backpressure test, long enough to fill the block
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PRINT_CAP        = 50;

    // one storage command word as it leaves the block
    typedef struct packed {
        logic        store_op;
        logic [4:0]  word_index;
        logic [15:0] word_data;
        logic        last_of_run;
    } store_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    sysex_nsp_byte_if byte_chan ();
    sysex_nsp_cmd_if  cmd_chan ();
    sysex_nsp_cfg_if  cfg_chan ();

    sysex_name_setting_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (byte_chan),
        .out_chan (cmd_chan),
        .cfg_chan (cfg_chan)
    );

    // parser mirror: position in the message, id being built, name so far
    logic [31:0] header_sig = SIG_RESET;
    int          parse_pos  = 0;
    logic [15:0] product_id = '0;
    logic [7:0]  name_bytes [NAME_MAX_DEF];

    store_cmd_t expected_cmds[$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    bit  src_idling = 1'b1;
    bit  sink_idling = 1'b1;
    bit  long_hold   = 1'b0;

    // ---------------------------------------------------------------
    // mirror of the parser, advanced once per accepted byte
    // ---------------------------------------------------------------

    function automatic logic [7:0] sig_byte(int k);
        return header_sig[31 - 8 * k -: 8];
    endfunction

    function automatic void queue_cmd(logic op, int idx, logic [15:0] data, logic last);
        store_cmd_t c;
        c.store_op    = op;
        c.word_index  = 5'(idx);
        c.word_data   = data;
        c.last_of_run = last;
        expected_cmds.push_back(c);
    endfunction

    function automatic void predict_commands(logic [7:0] b);
        int len;
        int eff;
        // idle: only the first header byte moves us on
        if (parse_pos == 0) begin
            if (b == sig_byte(0))
                parse_pos = 1;
            return;
        end
        // rest of the header; a mismatch drops to idle without a retry
        if (parse_pos < HDR_LEN) begin
            if (b == sig_byte(parse_pos))
                parse_pos++;
            else
                parse_pos = 0;
            return;
        end
        // end byte closes the message, also inside the id phase
        if (b == END_BYTE) begin
            len = (parse_pos > HDR_LEN + ID_LEN) ? parse_pos - HDR_LEN - ID_LEN : 0;
            if (len > NAME_MAX_DEF)
                len = NAME_MAX_DEF;
            parse_pos = 0;
            // the name stops at its first zero byte
            eff = 0;
            while (eff < len && name_bytes[eff] != 8'h00)
                eff++;
            if (eff == 0) begin
                queue_cmd(OP_ERASE, 0, 16'h0000, 1'b1);
                return;
            end
            queue_cmd(OP_ERASE, 0, 16'h0000, 1'b0);
            queue_cmd(OP_PROGRAM, 0, 16'h0000, 1'b0);
            queue_cmd(OP_PROGRAM, 1, product_id, 1'b0);
            for (int i = 0; i < eff; i++)
                queue_cmd(OP_PROGRAM, i + 2, {8'h00, name_bytes[i]}, 1'b0);
            queue_cmd(OP_PROGRAM, eff + 2, 16'h0000, 1'b1);
            return;
        end
        // id nibbles, least significant first
        if (parse_pos < HDR_LEN + ID_LEN) begin
            if (parse_pos == HDR_LEN)
                product_id = {12'h000, b[3:0]};
            else
                product_id[4 * (parse_pos - HDR_LEN) +: 4] = b[3:0];
            parse_pos++;
            return;
        end
        // name bytes; anything past the buffer is dropped
        if (parse_pos - HDR_LEN - ID_LEN < NAME_MAX_DEF) begin
            name_bytes[parse_pos - HDR_LEN - ID_LEN] = b;
            parse_pos++;
        end
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // returns at the edge that took the word, valid still high
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_idling && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid     <= 1'b1;
        byte_chan.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_chan.ready);
        predict_commands(b);
        bytes_sent++;
    endtask

    task automatic send_header();
        for (int k = 0; k < HDR_LEN; k++)
            send_byte(sig_byte(k));
    endtask

    task automatic send_id(input logic [15:0] id, input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            b = {4'($urandom_range(0, 15)), id[4 * k +: 4]};
            // keep a well-formed id clear of the end byte
            if (b == END_BYTE)
                b[7:4] = 4'h0;
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] random_name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 19) == 0)
            return 8'h00;
        b = 8'($urandom_range(1, 255));
        if (b == END_BYTE)
            b = 8'hF6;
        return b;
    endfunction

    task automatic send_message(input int name_len);
        send_header();
        send_id(16'($urandom), ID_LEN);
        for (int i = 0; i < name_len; i++)
            send_byte(random_name_byte());
        send_byte(END_BYTE);
    endtask

    // lowers valid in the step of the last acceptance, then waits for the run to finish
    task automatic wait_drained(input int settle);
        byte_chan.valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // end bytes until the mirror says idle, so a write never lands mid-message
    task automatic flush_to_idle();
        while (parse_pos != 0)
            send_byte(END_BYTE);
    endtask

    task automatic write_signature(input logic [31:0] sig);
        cfg_chan.valid            <= 1'b1;
        cfg_chan.header_signature <= sig;
        do
            @(posedge clk);
        while (!cfg_chan.ready);
        cfg_chan.valid <= 1'b0;
        header_sig = sig;
        repeat (2) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------

    initial begin : cmd_receiver
        int n;
        cmd_chan.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                cmd_chan.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
            end else if (sink_idling && $urandom_range(0, 3) == 0) begin
                cmd_chan.ready <= 1'b0;
                n = $urandom_range(1, 4);
                repeat (n - 1) @(posedge clk);
            end else begin
                cmd_chan.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // checker: each command word against the oldest expectation
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk) begin
        store_cmd_t want;
        if (rst_n && cmd_chan.valid && cmd_chan.ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("command word with nothing expected");
            end else begin
                want = expected_cmds.pop_front();
                if (cmd_chan.store_op !== want.store_op)
                    report_mismatch($sformatf("store_op %b, want %b",
                                              cmd_chan.store_op, want.store_op));
                if (cmd_chan.word_index !== want.word_index)
                    report_mismatch($sformatf("word_index %0d, want %0d",
                                              cmd_chan.word_index, want.word_index));
                if (cmd_chan.word_data !== want.word_data)
                    report_mismatch($sformatf("word_data %h, want %h",
                                              cmd_chan.word_data, want.word_data));
                if (cmd_chan.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              cmd_chan.last_of_run, want.last_of_run));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // bytes at idle that are not the start byte, end byte included
    task automatic test_ignored_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // second byte wrong: back to idle, and the wrong byte is not a new start
    task automatic test_header_mismatch();
        send_byte(sig_byte(0));
        send_byte(sig_byte(0));
        send_byte(sig_byte(1));
        send_byte(sig_byte(2));
        send_byte(sig_byte(3));
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // end byte half way through the id: erase only
    task automatic test_end_in_id_phase();
        send_header();
        send_id(16'h00A5, 2);
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // full id of all-ones bytes, no name: erase only
    task automatic test_empty_name();
        send_header();
        repeat (ID_LEN) send_byte(8'hFF);
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // id of all-zero bytes, name cut at its zero byte
    task automatic test_zero_in_name();
        send_header();
        repeat (ID_LEN) send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'h42);
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // two bytes more than the buffer holds, extreme byte values first
    task automatic test_name_overflow();
        send_header();
        send_id(16'hFFFF, ID_LEN);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        for (int i = 4; i < NAME_MAX_DEF + 2; i++)
            send_byte(8'(8'h40 + i));
        send_byte(END_BYTE);
        wait_drained(SETTLE_CYCLES);
    endtask

    // receiver holds off while a second message is offered behind the first run
    task automatic test_output_backpressure();
        long_hold = 1'b1;
        send_message(8);
        send_message(5);
        wait_drained(SETTLE_CYCLES);
    endtask

    // mostly well-formed messages, the rest broken ones and noise
    task automatic test_random_traffic(input logic [31:0] sig, input bit idling,
                                       input int budget);
        int stop_at;
        int kind;
        int len;
        flush_to_idle();
        wait_drained(SETTLE_CYCLES);
        write_signature(sig);
        src_idling  = idling;
        sink_idling = idling;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                if ($urandom_range(0, 3) == 0)
                    send_byte(8'($urandom));
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                                 : $urandom_range(7, NAME_MAX_DEF + 2);
                send_message(len);
            end else if (kind == 7) begin
                send_header();
                send_id(16'($urandom), $urandom_range(0, ID_LEN - 1));
                send_byte(END_BYTE);
            end else if (kind == 8) begin
                len = $urandom_range(1, HDR_LEN - 1);
                for (int k = 0; k < len; k++)
                    send_byte(sig_byte(k));
                send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
        flush_to_idle();
        wait_drained(SETTLE_CYCLES);
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        rst_n                     = 1'b0;
        byte_chan.valid           = 1'b0;
        byte_chan.data_byte       = 8'h00;
        cfg_chan.valid            = 1'b0;
        cfg_chan.header_signature = 32'h0000_0000;
        for (int i = 0; i < NAME_MAX_DEF; i++)
            name_bytes[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset signature
        test_ignored_bytes();
        test_header_mismatch();
        test_end_in_id_phase();
        test_empty_name();
        test_zero_in_name();
        test_name_overflow();
        test_output_backpressure();

        // random part over several signatures, the last without any idling
        test_random_traffic(32'hFFFF_FFFF, 1'b1, 8);
        test_random_traffic(32'h0000_0000, 1'b1, 8);
        test_random_traffic(32'hF7F7_F7F7, 1'b1, 8);
        test_random_traffic(32'($urandom), 1'b1, 8);
        test_random_traffic(SIG_RESET, 1'b0, 8);

        wait_drained(END_CYCLES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hung handshake guard
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
